>>> hw/rtl/bod_pkg.sv
// ----------------------------------------------------------------------------
// bod_pkg: shared types and constants of the breakpoint overlay debug unit
// Slot and RAM geometry, operation codes and the slot interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bod_pkg;

  // number of breakpoint slots (1 to 16) and slot field width
  localparam int BOD_SLOTS  = 16;
  localparam int BOD_SLOT_W = 4;

  // overlay RAM geometry
  localparam int BOD_RAM_DEPTH = 256;
  localparam int BOD_RAM_AW    = 8;

  // page that maps to data RAM while stopped
  localparam logic [7:0] DATA_PAGE = 8'hFF;

  // operation codes carried in in_tuser
  localparam logic [2:0] KIND_READ       = 3'd0;
  localparam logic [2:0] KIND_WRITE      = 3'd1;
  localparam logic [2:0] KIND_POKE_CODE  = 3'd2;
  localparam logic [2:0] KIND_POKE_DATA  = 3'd3;
  localparam logic [2:0] KIND_PEEK_DATA  = 3'd4;
  localparam logic [2:0] KIND_SET_SLOT   = 3'd5;
  localparam logic [2:0] KIND_CLEAR_SLOT = 3'd6;

  // source of the returned byte
  localparam logic [1:0] RSEL_NONE = 2'd0;
  localparam logic [1:0] RSEL_CODE = 2'd1;
  localparam logic [1:0] RSEL_DATA = 2'd2;

  // slot table update request
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [BOD_SLOT_W-1:0] idx;
    logic [15:0]           addr;
  } bod_slot_req_t;

  // slot table lookup answer
  typedef struct packed {
    logic                  hit;
    logic [BOD_SLOT_W-1:0] idx;
  } bod_slot_hit_t;

endpackage

`default_nettype wire

>>> hw/rtl/bod_slot_match.sv
// ----------------------------------------------------------------------------
// bod_slot_match: breakpoint slot table
// Holds slot addresses and the active mask, finds the lowest active slot
// whose address equals the lookup address.
// ----------------------------------------------------------------------------
`default_nettype none

module bod_slot_match
  import bod_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [15:0]   lookup_addr,
  input  wire bod_slot_req_t req,
  output bod_slot_hit_t      hit
);

  logic [15:0]          slot_addr_r [BOD_SLOTS];
  logic [BOD_SLOTS-1:0] active_r;
  logic [BOD_SLOTS-1:0] active_nxt;

  // priority search, lowest slot wins
  always_comb begin
    hit = '0;
    for (int i = BOD_SLOTS - 1; i >= 0; i--) begin
      if (active_r[i] && slot_addr_r[i] == lookup_addr) begin
        hit.hit = 1'b1;
        hit.idx = BOD_SLOT_W'(i);
      end
    end
  end

  // mask update
  always_comb begin
    active_nxt = active_r;
    for (int i = 0; i < BOD_SLOTS; i++) begin
      if (req.idx == BOD_SLOT_W'(i)) begin
        if (req.set) active_nxt[i] = 1'b1;
        if (req.clr) active_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // slot addresses, no reset: only compared once active
  always_ff @(posedge clk) begin
    for (int i = 0; i < BOD_SLOTS; i++) begin
      if (req.set && req.idx == BOD_SLOT_W'(i)) slot_addr_r[i] <= req.addr;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/breakpoint_overlay_debug_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_overlay_debug_unit: breakpoint and overlay unit on a CPU bus
// Catches reads at breakpoint addresses, then serves a stub from code and
// data overlay RAMs until the CPU reads the base address again.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: kind; tdata: address, data, slot
//  out_    | out | out_tvalid/tready  | tdata: claimed, read_data, stopped,
//          |     |                    |        released
//
//  Decision and RAM access happen on the accept edge; the registered RAM byte
//  is then loaded into the output register when that register is free.
//  in_tready drops while a word is pending; it stays high while a result waits.
//  A stalled output holds the pending word and blocks further input.
//  Reset clears the mode, stub base, hit slot and slot mask; the overlay
//  RAMs and slot addresses hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_overlay_debug_unit
  import bod_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  input  wire logic [31:0] in_tdata,   // [15:0] address, [23:16] data, [27:24] slot
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [0] claimed, [8:1] read_data, [9] stopped,
                                       // [10] released
);

  // item fields
  logic [2:0]            kind;
  logic [15:0]           addr;
  logic [7:0]            wdata;
  logic [BOD_SLOT_W-1:0] slot;

  assign kind  = in_tuser;
  assign addr  = in_tdata[15:0];
  assign wdata = in_tdata[23:16];
  assign slot  = in_tdata[27:24];

  // control state
  logic                  stop_mode_r, stop_mode_nxt;
  logic [15:0]           stub_base_r, stub_base_nxt;
  logic [BOD_SLOT_W-1:0] hit_slot_r,  hit_slot_nxt;
  logic                  pend_r,      pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // pending result fields
  logic                  pend_claimed_r, pend_claimed_nxt;
  logic                  pend_released_r, pend_released_nxt;
  logic                  pend_stopped_r, pend_stopped_nxt;
  logic [1:0]            pend_rsel_r, pend_rsel_nxt;
  logic [15:0]           out_tdata_r;

  // RAM ports
  logic                  code_re, code_we, data_re, data_we;
  logic [BOD_RAM_AW-1:0] code_addr, data_addr;
  logic [7:0]            code_mem [BOD_RAM_DEPTH];
  logic [7:0]            data_mem [BOD_RAM_DEPTH];
  logic [7:0]            code_q_r, data_q_r;

  logic                  acc;
  logic                  out_free;
  logic                  in_page;
  logic [15:0]           base_ofs;
  logic                  slot_ok;
  bod_slot_req_t         slot_req;
  bod_slot_hit_t         slot_hit;

  assign in_tready = !pend_r;
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_page   = addr[15:8] == DATA_PAGE;
  assign base_ofs  = addr - stub_base_r;
  assign slot_ok   = {1'b0, slot} < (BOD_SLOT_W + 1)'(BOD_SLOTS);

  bod_slot_match u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_addr (addr),
    .req         (slot_req),
    .hit         (slot_hit)
  );

  // decode of the accepted word
  always_comb begin
    stop_mode_nxt     = stop_mode_r;
    stub_base_nxt     = stub_base_r;
    hit_slot_nxt      = hit_slot_r;
    pend_claimed_nxt  = 1'b0;
    pend_released_nxt = 1'b0;
    pend_rsel_nxt     = RSEL_NONE;
    code_re           = 1'b0;
    code_we           = 1'b0;
    data_re           = 1'b0;
    data_we           = 1'b0;
    code_addr         = addr[BOD_RAM_AW-1:0];
    data_addr         = addr[BOD_RAM_AW-1:0];
    slot_req          = '0;
    slot_req.idx      = slot;
    slot_req.addr     = addr;
    if (acc) begin
      case (kind)
        KIND_READ: begin
          if (!stop_mode_r) begin
            if (slot_hit.hit) begin
              stop_mode_nxt    = 1'b1;
              stub_base_nxt    = addr;
              hit_slot_nxt     = slot_hit.idx;
              pend_claimed_nxt = 1'b1;
              pend_rsel_nxt    = RSEL_CODE;
              code_re          = 1'b1;
              code_addr        = '0;
            end
          end else if (addr == stub_base_r) begin
            // end of stub: back to run mode, retire the slot
            stop_mode_nxt     = 1'b0;
            pend_released_nxt = 1'b1;
            slot_req.clr      = 1'b1;
            slot_req.idx      = hit_slot_r;
          end else begin
            pend_claimed_nxt = 1'b1;
            if (in_page) begin
              pend_rsel_nxt = RSEL_DATA;
              data_re       = 1'b1;
            end else begin
              pend_rsel_nxt = RSEL_CODE;
              code_re       = 1'b1;
              code_addr     = base_ofs[BOD_RAM_AW-1:0];
            end
          end
        end
        KIND_WRITE: begin
          if (stop_mode_r && in_page) begin
            data_we          = 1'b1;
            pend_claimed_nxt = 1'b1;
          end
        end
        KIND_POKE_CODE: code_we = 1'b1;
        KIND_POKE_DATA: data_we = 1'b1;
        KIND_PEEK_DATA: begin
          data_re       = 1'b1;
          pend_rsel_nxt = RSEL_DATA;
        end
        KIND_SET_SLOT:   slot_req.set = slot_ok;
        KIND_CLEAR_SLOT: slot_req.clr = slot_ok;
        default: ;
      endcase
    end
    pend_stopped_nxt = stop_mode_nxt;
  end

  // handshake sequencing
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (acc) pend_nxt = 1'b1;
    if (pend_r && out_free) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mode_r <= 1'b0;
      stub_base_r <= '0;
      hit_slot_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stop_mode_r <= stop_mode_nxt;
      stub_base_r <= stub_base_nxt;
      hit_slot_r  <= hit_slot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_claimed_r  <= pend_claimed_nxt;
      pend_released_r <= pend_released_nxt;
      pend_stopped_r  <= pend_stopped_nxt;
      pend_rsel_r     <= pend_rsel_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_tdata_r[0]     <= pend_claimed_r;
      out_tdata_r[8:1]   <= (pend_rsel_r == RSEL_CODE) ? code_q_r :
                            (pend_rsel_r == RSEL_DATA) ? data_q_r : 8'h00;
      out_tdata_r[9]     <= pend_stopped_r;
      out_tdata_r[10]    <= pend_released_r;
      out_tdata_r[15:11] <= '0;
    end
  end

  // code overlay RAM, read data held until next read
  always_ff @(posedge clk) begin
    if (code_we) code_mem[code_addr] <= wdata;
    if (code_re) code_q_r <= code_mem[code_addr];
  end

  // data overlay RAM
  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_addr] <= wdata;
    if (data_re) data_q_r <= data_mem[data_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  a_rel_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[10] |-> !out_tdata_r[9] && !out_tdata_r[0])
    else $error("release word reports stop mode or claim");

  a_acc_pend: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> pend_r && !in_tready)
    else $error("accepted word not held pending");

  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_free |=> out_valid_r && !pend_r)
    else $error("pending word not moved to output");

  a_hit_stop: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_READ && !stop_mode_r && slot_hit.hit |=> stop_mode_r)
    else $error("breakpoint hit did not enter stop mode");

endmodule

`default_nettype wire

>>> sim/breakpoint_overlay_debug_unit_test.sv
// ----------------------------------------------------------------------------
// breakpoint_overlay_debug_unit_test: self-checking bench for the debug unit
// Loads both overlay RAMs, runs a directed pass over breakpoint entry, stub
// service and release, then random breakpoint episodes mixed with noise.
// Every result word is checked field by field against an in-bench predictor,
// with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------

module breakpoint_overlay_debug_unit_test;
  import bod_pkg::*;

  // kind code the unit leaves unused
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_OPS = 860;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  slot;
  } bus_op_t;

  typedef struct {
    logic       claimed;
    logic [7:0] rdata;
    logic       stopped;
    logic       released;
  } bus_reply_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_LOSSY, SINK_SPARSE, SINK_BURSTY} sink_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;   // [2:0] kind
  logic [31:0] in_tdata = '0;   // [15:0] address, [23:16] data, [27:24] slot
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [0] claimed, [8:1] read_data, [9] stopped, [10] released

  breakpoint_overlay_debug_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  bus_op_t     bus_ops[$];
  bus_reply_t  owed_replies[$];
  logic [15:0] bp_addrs[$];
  int          ops_queued = 0;
  int          fails = 0;
  int          replies_checked = 0;
  int          hits_seen = 0;
  int          releases_seen = 0;

  // predictor state
  logic        halted = 1'b0;
  logic [15:0] slot_addr [BOD_SLOTS];
  logic [15:0] slot_live = '0;
  logic [15:0] stub_base = '0;
  logic [3:0]  hit_slot = '0;
  logic [7:0]  code_ram [BOD_RAM_DEPTH];
  logic [7:0]  data_ram [BOD_RAM_DEPTH];

  // advance the predicted unit by one bus word, return the reply it owes
  function automatic bus_reply_t overlay_step(bus_op_t op);
    bus_reply_t r;
    logic [7:0] idx;
    logic [7:0] rel;
    logic       found;
    int         s;
    r = '{claimed: 1'b0, rdata: 8'h00, stopped: 1'b0, released: 1'b0};
    idx = op.addr[7:0];
    found = 1'b0;
    case (op.kind)
      KIND_READ: begin
        if (!halted) begin
          // lowest matching live slot takes the hit
          for (s = 0; s < BOD_SLOTS; s++) begin
            if (!found && slot_live[s] && slot_addr[s] == op.addr) begin
              found = 1'b1;
              halted = 1'b1;
              stub_base = op.addr;
              hit_slot = s[3:0];
              r.claimed = 1'b1;
              r.rdata = code_ram[0];
              hits_seen++;
            end
          end
        end else if (op.addr == stub_base) begin
          // stub done: back to run mode, hit slot retired, read not claimed
          halted = 1'b0;
          slot_live[hit_slot] = 1'b0;
          r.released = 1'b1;
          releases_seen++;
        end else begin
          r.claimed = 1'b1;
          if (op.addr[15:8] == DATA_PAGE) begin
            r.rdata = data_ram[idx];
          end else begin
            rel = op.addr[7:0] - stub_base[7:0];
            r.rdata = code_ram[rel];
          end
        end
      end
      KIND_WRITE: begin
        if (halted && op.addr[15:8] == DATA_PAGE) begin
          data_ram[idx] = op.data;
          r.claimed = 1'b1;
        end
      end
      KIND_POKE_CODE: code_ram[idx] = op.data;
      KIND_POKE_DATA: data_ram[idx] = op.data;
      KIND_PEEK_DATA: r.rdata = data_ram[idx];
      KIND_SET_SLOT: begin
        if (op.slot < BOD_SLOTS) begin
          slot_addr[op.slot] = op.addr;
          slot_live[op.slot] = 1'b1;
        end
      end
      KIND_CLEAR_SLOT: begin
        if (op.slot < BOD_SLOTS) slot_live[op.slot] = 1'b0;
      end
      default: ;
    endcase
    r.stopped = halted;
    return r;
  endfunction

  function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  task automatic push_op(logic [2:0] kind, logic [15:0] addr, logic [7:0] data,
                         logic [3:0] slot);
    bus_op_t op;
    op = '{kind: kind, addr: addr, data: data, slot: slot};
    bus_ops.push_back(op);
    ops_queued++;
  endtask

  task automatic note_breakpoint(logic [15:0] addr);
    bp_addrs.push_back(addr);
    if (bp_addrs.size() > 32) void'(bp_addrs.pop_front());
  endtask

  // any kind, address biased towards known breakpoints and the data page
  task automatic push_noise();
    logic [2:0]  k;
    logic [15:0] a;
    k = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0, 1: a = (bp_addrs.size() != 0) ? bp_addrs[$urandom_range(0, bp_addrs.size() - 1)]
                                       : 16'($urandom);
      2: a = {DATA_PAGE, 8'($urandom)};
      default: a = 16'($urandom);
    endcase
    if (k == KIND_SET_SLOT) note_breakpoint(a);
    push_op(k, a, 8'($urandom), 4'($urandom));
  endtask

  // one word of stub traffic around base address a
  task automatic push_stub_word(logic [15:0] a);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_op(KIND_READ, a + 16'($urandom_range(1, 300)), 8'($urandom),
                          4'($urandom));
      4, 5: push_op(KIND_READ, {DATA_PAGE, 8'($urandom)}, 8'($urandom), 4'($urandom));
      6: push_op(KIND_WRITE, {DATA_PAGE, 8'($urandom)}, 8'($urandom), 4'($urandom));
      7: push_op(KIND_WRITE, {8'($urandom_range(0, 254)), 8'($urandom)}, 8'($urandom),
                 4'($urandom));
      8: push_op(3'($urandom_range(KIND_POKE_CODE, KIND_PEEK_DATA)), 16'($urandom),
                 8'($urandom), 4'($urandom));
      default: push_noise();
    endcase
  endtask

  // stimulus: RAM load, directed pass, random episodes; then wait for the end
  initial begin
    logic [15:0] a;
    logic [3:0]  s;
    int          random_start;
    // load every overlay byte so no read ever touches an unwritten entry
    for (int i = 0; i < BOD_RAM_DEPTH; i++)
      push_op(KIND_POKE_CODE, {8'($urandom), 8'(i)}, 8'($urandom), 4'($urandom));
    for (int i = 0; i < BOD_RAM_DEPTH; i++)
      push_op(KIND_POKE_DATA, {8'($urandom), 8'(i)}, 8'($urandom), 4'($urandom));

    // directed: extreme addresses and slots, base inside the data page
    push_op(KIND_SET_SLOT, 16'h0000, 8'h00, 4'd0);
    push_op(KIND_SET_SLOT, 16'hFFFF, 8'hFF, 4'd15);
    push_op(KIND_WRITE, 16'hFF10, 8'h3C, 4'd0);          // run mode write, ignored
    push_op(KIND_READ, 16'h1234, 8'h00, 4'd0);           // miss
    push_op(KIND_READ, 16'hFFFF, 8'hFF, 4'd15);          // hit on slot 15
    push_op(KIND_READ, 16'hFF10, 8'h00, 4'd0);           // data page read
    push_op(KIND_WRITE, 16'hFF10, 8'hA5, 4'd0);          // absorbed
    push_op(KIND_WRITE, 16'h1000, 8'h5A, 4'd0);          // outside data page, ignored
    push_op(KIND_READ, 16'hFF10, 8'h00, 4'd0);
    push_op(KIND_READ, 16'h0005, 8'h00, 4'd0);           // code offset wraps
    push_op(KIND_PEEK_DATA, 16'hAB10, 8'h00, 4'd0);
    push_op(KIND_POKE_CODE, 16'h1206, 8'hFF, 4'd15);
    push_op(KIND_POKE_DATA, 16'hFF11, 8'h00, 4'd0);
    push_op(KIND_UNUSED, 16'hFFFF, 8'hFF, 4'd15);
    push_op(KIND_READ, 16'hFFFF, 8'h00, 4'd0);           // release inside data page
    push_op(KIND_READ, 16'h0000, 8'h00, 4'd0);           // hit on slot 0
    push_op(KIND_READ, 16'h00FF, 8'h00, 4'd0);
    push_op(KIND_READ, 16'h0000, 8'h00, 4'd0);           // release
    // two slots on one address: lower one first, the other after release
    push_op(KIND_SET_SLOT, 16'h8001, 8'h00, 4'd9);
    push_op(KIND_SET_SLOT, 16'h8001, 8'h00, 4'd3);
    repeat (5) push_op(KIND_READ, 16'h8001, 8'h00, 4'd0);
    // cleared slot no longer fires
    push_op(KIND_SET_SLOT, 16'h4000, 8'h00, 4'd5);
    push_op(KIND_CLEAR_SLOT, 16'h0000, 8'h00, 4'd5);
    push_op(KIND_READ, 16'h4000, 8'h00, 4'd0);
    push_op(KIND_UNUSED, 16'h0000, 8'h00, 4'd0);

    // random: mostly complete breakpoint episodes, some loose noise
    random_start = ops_queued;
    while (ops_queued - random_start < RANDOM_OPS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) push_noise();
      end else begin
        s = 4'($urandom);
        case ($urandom_range(0, 9))
          0: a = 16'h0000;
          1: a = 16'hFFFF;
          2: a = {DATA_PAGE, 8'($urandom)};
          default: a = 16'($urandom);
        endcase
        note_breakpoint(a);
        push_op(KIND_SET_SLOT, a, 8'($urandom), s);
        repeat ($urandom_range(0, 2)) push_noise();
        push_op(KIND_READ, a, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 12)) push_stub_word(a);
        push_op(KIND_READ, a, 8'($urandom), 4'($urandom));
        if ($urandom_range(0, 4) == 0)
          push_op(KIND_CLEAR_SLOT, 16'($urandom), 8'($urandom), 4'($urandom));
      end
    end

    // drain
    @(posedge rst_n);
    while (bus_ops.size() != 0 || in_tvalid) @(negedge clk);
    while (owed_replies.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("sent %0d bus words (%0d random), %0d breakpoint hits, %0d releases",
             ops_queued, ops_queued - random_start, hits_seen, releases_seen);
    $display("checked %0d result words, %0d failures", replies_checked, fails);
    if (fails == 0) begin
      $display("breakpoint_overlay_debug_unit_test OK");
    end else begin
      $display("breakpoint_overlay_debug_unit_test NOT OK");
    end
    $finish;
  end

  // reset: held low at start, released on a falling clock edge
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    #3000000;
    $display("timeout with %0d words pending, %0d results owed", bus_ops.size(),
             owed_replies.size());
    $display("breakpoint_overlay_debug_unit_test NOT OK");
    $finish;
  end

  // input acceptance: predict the reply for every word taken
  logic in_taken = 1'b0;

  always @(posedge clk) begin
    bus_op_t seen;
    if (rst_n && in_tvalid && in_tready) begin
      seen = '{kind: in_tuser, addr: in_tdata[15:0], data: in_tdata[23:16],
               slot: in_tdata[27:24]};
      owed_replies.push_back(overlay_step(seen));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // driver: bursts of words with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    bus_op_t next_op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (bus_ops.size() != 0) begin
        next_op = bus_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_op.kind;
        in_tdata <= {4'b0000, next_op.slot, next_op.data, next_op.addr};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: the stall style is redrawn at random whenever its run count expires
  sink_style_t sink_style = SINK_OPEN;
  int          style_left = 0;
  int          hold_left = 0;
  logic [1:0]  sink_tick = '0;

  always @(negedge clk) begin
    if (style_left == 0) begin
      sink_style = sink_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(64, 256);
    end else begin
      style_left--;
    end
    sink_tick++;
    case (sink_style)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_LOSSY:  out_tready <= ($urandom_range(0, 3) != 0);
      SINK_SPARSE: out_tready <= (sink_tick == 2'b00);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 10);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // monitor: each result word against the oldest owed reply
  always @(posedge clk) begin
    bus_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_replies.size() == 0) begin
        fails++;
        $display("%0t: result word %h with nothing expected", $time, out_tdata);
      end else begin
        want = owed_replies.pop_front();
        compare_field("claimed", 8'(want.claimed), 8'(out_tdata[0]));
        compare_field("read_data", want.rdata, out_tdata[8:1]);
        compare_field("stopped", 8'(want.stopped), 8'(out_tdata[9]));
        compare_field("released", 8'(want.released), 8'(out_tdata[10]));
        compare_field("padding", 8'h00, 8'(out_tdata[15:11]));
        replies_checked++;
      end
    end
  end

endmodule
